// ===== rtl/cdq_pkg.sv =====
// Shared types and codes for the circular deque.
`timescale 1ns / 1ps

package cdq_pkg;

    typedef enum logic [1:0] {
        ACT_PUSH_FRONT = 2'd0,
        ACT_PUSH_REAR  = 2'd1,
        ACT_POP_FRONT  = 2'd2,
        ACT_POP_REAR   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_PUSH_FRONT,
        OP_PUSH_REAR,
        OP_POP_FRONT,
        OP_POP_REAR
    } cell_op_t;

endpackage

// ===== rtl/circular_deque.sv =====
// Top level of the circular deque: cell chain, operation sequencer and result register.
//
//   channel  | handshake            | payload
//   ---------+----------------------+----------------------------------
//   input    | in_valid / in_ready  | action, value
//   output   | out_valid / out_ready| status, removed_value, occupancy
//
// Elements sit left-justified in the cell chain, the front in cell 0.
// Pushes, front pops and failed operations keep the sequencer idle; their result
// is loaded as they are accepted. A successful rear pop enters the collect state:
// the rear element travels down the collect stages of the chain, one cell per
// cycle, to cell 0, and is loaded once tick_reg reaches DEPTH and the output is free.
// Reset empties the deque; a stalled result holds in_ready low.
`timescale 1ns / 1ps

module circular_deque #(
    parameter int DEPTH = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         action,
    input  logic signed [31:0] value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic signed [31:0] removed_value,
    output logic [3:0]         occupancy
);

    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic {
        S_IDLE,
        S_COLLECT
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic [CW-1:0]       tick_reg;
    logic [CW-1:0]       tick_next;
    logic                out_valid_reg;
    logic [1:0]          status_reg;
    logic signed [31:0]  removed_reg;
    logic [3:0]          occupancy_reg;

    cdq_pkg::cell_op_t   op;
    cdq_pkg::status_t    st;
    logic signed [31:0]  rem;
    logic                load;
    logic                accept;
    logic                out_free;
    logic                full;
    logic                empty;
    logic [CW+3:0]       count_ext;

    logic signed [31:0]  cell_val [DEPTH];
    logic                cell_vld [DEPTH];
    logic signed [31:0]  cell_col [DEPTH];

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            logic signed [31:0] lval;
            logic               lvld;
            logic signed [31:0] rval;
            logic               rvld;
            logic signed [31:0] rcol;

            if (g == 0)
            begin : g_first
                assign lval = value;
                assign lvld = 1'b1;
            end
            else
            begin : g_mid_l
                assign lval = cell_val[g-1];
                assign lvld = cell_vld[g-1];
            end

            if (g == DEPTH - 1)
            begin : g_last
                assign rval = '0;
                assign rvld = 1'b0;
                assign rcol = '0;
            end
            else
            begin : g_mid_r
                assign rval = cell_val[g+1];
                assign rvld = cell_vld[g+1];
                assign rcol = cell_col[g+1];
            end

            cdq_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .op        (op),
                .push_val  (value),
                .left_val  (lval),
                .left_vld  (lvld),
                .right_val (rval),
                .right_vld (rvld),
                .right_col (rcol),
                .val       (cell_val[g]),
                .vld       (cell_vld[g]),
                .col       (cell_col[g])
            );
        end
    endgenerate

    assign full     = cell_vld[DEPTH-1];
    assign empty    = !cell_vld[0];
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE) && out_free;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        op         = cdq_pkg::OP_HOLD;
        st         = cdq_pkg::ST_DONE;
        rem        = '0;
        load       = 1'b0;
        count_next = count_reg;
        tick_next  = tick_reg;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (cdq_pkg::action_t'(action))
                        cdq_pkg::ACT_PUSH_FRONT,
                        cdq_pkg::ACT_PUSH_REAR:
                        begin
                            load = 1'b1;
                            if (full)
                            begin
                                st = cdq_pkg::ST_FULL;
                            end
                            else
                            begin
                                op = (cdq_pkg::action_t'(action) == cdq_pkg::ACT_PUSH_FRONT)
                                     ? cdq_pkg::OP_PUSH_FRONT : cdq_pkg::OP_PUSH_REAR;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        cdq_pkg::ACT_POP_FRONT:
                        begin
                            load = 1'b1;
                            if (empty)
                            begin
                                st = cdq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                op         = cdq_pkg::OP_POP_FRONT;
                                rem        = cell_val[0];
                                count_next = count_reg - CW'(1);
                            end
                        end
                        default:
                        begin
                            if (empty)
                            begin
                                load = 1'b1;
                                st   = cdq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                tick_next  = '0;
                                state_next = S_COLLECT;
                            end
                        end
                    endcase
                end
            end
            S_COLLECT:
            begin
                if (tick_reg != CW'(DEPTH))
                begin
                    tick_next = tick_reg + CW'(1);
                end
                else if (out_free)
                begin
                    op         = cdq_pkg::OP_POP_REAR;
                    rem        = cell_col[0];
                    load       = 1'b1;
                    count_next = count_reg - CW'(1);
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign count_ext = {4'b0000, count_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            tick_reg      <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= '0;
            removed_reg   <= '0;
            occupancy_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            tick_reg  <= tick_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
                status_reg    <= st;
                removed_reg   <= rem;
                occupancy_reg <= count_ext[3:0];
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign removed_value = removed_reg;
    assign occupancy     = occupancy_reg;

endmodule

// ===== rtl/cdq_cell.sv =====
// One storage cell of the deque chain, holding one element and its rear-collect stage.
`timescale 1ns / 1ps

module cdq_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  cdq_pkg::cell_op_t   op,
    input  logic signed [31:0]  push_val,
    input  logic signed [31:0]  left_val,
    input  logic                left_vld,
    input  logic signed [31:0]  right_val,
    input  logic                right_vld,
    input  logic signed [31:0]  right_col,
    output logic signed [31:0]  val,
    output logic                vld,
    output logic signed [31:0]  col
);

    logic signed [31:0] val_reg;
    logic signed [31:0] val_next;
    logic               vld_reg;
    logic               vld_next;
    logic signed [31:0] col_reg;
    logic signed [31:0] col_next;
    logic               is_last;

    assign is_last = vld_reg && !right_vld;

    always_comb
    begin
        val_next = val_reg;
        vld_next = vld_reg;
        case (op)
            cdq_pkg::OP_PUSH_FRONT:
            begin
                val_next = left_val;
                vld_next = left_vld;
            end
            cdq_pkg::OP_PUSH_REAR:
            begin
                if (!vld_reg && left_vld)
                begin
                    val_next = push_val;
                    vld_next = 1'b1;
                end
            end
            cdq_pkg::OP_POP_FRONT:
            begin
                val_next = right_val;
                vld_next = right_vld;
            end
            cdq_pkg::OP_POP_REAR:
            begin
                if (is_last)
                begin
                    vld_next = 1'b0;
                end
            end
            default:
            begin
                val_next = val_reg;
                vld_next = vld_reg;
            end
        endcase
        col_next = is_last ? val_reg : right_col;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        col_reg <= col_next;
    end

    assign val = val_reg;
    assign vld = vld_reg;
    assign col = col_reg;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the circular deque, with directed, random and back-pressure tests.
`timescale 1ns / 1ps

module tb;

    localparam int DEPTH = 8;
    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        cdq_pkg::status_t st;
        logic [31:0]      removed;
        logic [3:0]       occ;
    } deque_result_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    cdq_pkg::action_t   action;
    logic signed [31:0] value;
    logic               out_valid;
    logic               out_ready;
    logic [1:0]         status;
    logic signed [31:0] removed_value;
    logic [3:0]         occupancy;

    logic [31:0]   ring [DEPTH];
    int            front_idx;
    int            rear_idx;
    bit            ring_empty;
    deque_result_t pending_results [$];

    int errors;
    int idle_in;
    int idle_out;
    int hold_left;
    int quiet_cycles;

    circular_deque #(
        .DEPTH(DEPTH)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .removed_value(removed_value),
        .occupancy    (occupancy)
    );

    always #10 clk = ~clk;

    function automatic int ring_count();
        if (ring_empty)
            return 0;
        return ((rear_idx + DEPTH - front_idx) % DEPTH) + 1;
    endfunction

    function automatic deque_result_t deque_apply(cdq_pkg::action_t act, logic [31:0] val);
        deque_result_t r;
        r.st = cdq_pkg::ST_DONE;
        r.removed = '0;
        if (act == cdq_pkg::ACT_PUSH_FRONT || act == cdq_pkg::ACT_PUSH_REAR)
        begin
            if (ring_count() == DEPTH)
            begin
                r.st = cdq_pkg::ST_FULL;
            end
            else if (ring_empty)
            begin
                front_idx = 0;
                rear_idx = 0;
                ring_empty = 1'b0;
                ring[0] = val;
            end
            else if (act == cdq_pkg::ACT_PUSH_FRONT)
            begin
                front_idx = (front_idx + DEPTH - 1) % DEPTH;
                ring[front_idx] = val;
            end
            else
            begin
                rear_idx = (rear_idx + 1) % DEPTH;
                ring[rear_idx] = val;
            end
        end
        else if (ring_empty)
        begin
            r.st = cdq_pkg::ST_EMPTY;
        end
        else
        begin
            r.removed = (act == cdq_pkg::ACT_POP_FRONT) ? ring[front_idx] : ring[rear_idx];
            if (front_idx == rear_idx)
            begin
                ring_empty = 1'b1;
                front_idx = 0;
                rear_idx = 0;
            end
            else if (act == cdq_pkg::ACT_POP_FRONT)
            begin
                front_idx = (front_idx + 1) % DEPTH;
            end
            else
            begin
                rear_idx = (rear_idx + DEPTH - 1) % DEPTH;
            end
        end
        r.occ = 4'(ring_count());
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_item(cdq_pkg::action_t act, logic [31:0] val);
        while (idle_in > 0 && $urandom_range(99) < idle_in)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        value <= val;
        do
            @(posedge clk);
        while (!in_ready);
        pending_results.push_back(deque_apply(act, val));
        @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= idle_out);
        end
    end

    always @(posedge clk)
    begin : check_results
        deque_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with nothing pending: status %0d removed_value %0h occupancy %0d",
                       status, removed_value, occupancy);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.st)
                begin
                    $error("status: expected %0d, actual %0d", want.st, status);
                    errors++;
                end
                if (removed_value !== want.removed)
                begin
                    $error("removed_value: expected %0h, actual %0h", want.removed, removed_value);
                    errors++;
                end
                if (occupancy !== want.occ)
                begin
                    $error("occupancy: expected %0d, actual %0d", want.occ, occupancy);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else if (in_valid || pending_results.size() != 0)
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [31:0] pick_value();
        case ($urandom_range(15))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // Mode 0 mostly pushes, mode 1 mostly pops, mode 2 is balanced.
    function automatic cdq_pkg::action_t pick_action(int mode);
        int push_pct;
        push_pct = (mode == 0) ? 80 : (mode == 1) ? 20 : 50;
        if ($urandom_range(99) < push_pct)
            return $urandom_range(1) ? cdq_pkg::ACT_PUSH_REAR : cdq_pkg::ACT_PUSH_FRONT;
        return $urandom_range(1) ? cdq_pkg::ACT_POP_REAR : cdq_pkg::ACT_POP_FRONT;
    endfunction

    task automatic run_random(int count);
        int mode;
        mode = 2;
        for (int i = 0; i < count; i++)
        begin
            if (i % 24 == 0)
                mode = $urandom_range(2);
            send_item(pick_action(mode), pick_value());
        end
    endtask

    task automatic test_empty_pops();
        send_item(cdq_pkg::ACT_POP_FRONT, 32'hdead_beef);
        send_item(cdq_pkg::ACT_POP_REAR, 32'h0123_4567);
    endtask

    task automatic test_fill_wrap_drain();
        send_item(cdq_pkg::ACT_PUSH_FRONT, 32'h7fff_ffff);
        send_item(cdq_pkg::ACT_PUSH_FRONT, 32'h8000_0000);
        send_item(cdq_pkg::ACT_PUSH_REAR, 32'h0000_0000);
        send_item(cdq_pkg::ACT_PUSH_REAR, 32'hffff_ffff);
        send_item(cdq_pkg::ACT_PUSH_REAR, 32'h5555_5555);
        send_item(cdq_pkg::ACT_PUSH_FRONT, 32'haaaa_aaaa);
        send_item(cdq_pkg::ACT_PUSH_REAR, 32'h0000_0001);
        send_item(cdq_pkg::ACT_PUSH_FRONT, 32'h1234_5678);
        send_item(cdq_pkg::ACT_PUSH_REAR, 32'h0000_0005);
        send_item(cdq_pkg::ACT_PUSH_FRONT, 32'h0000_0006);
        for (int i = 0; i < DEPTH / 2; i++)
        begin
            send_item(cdq_pkg::ACT_POP_REAR, $urandom);
            send_item(cdq_pkg::ACT_POP_FRONT, $urandom);
        end
        send_item(cdq_pkg::ACT_POP_FRONT, 32'hffff_ffff);
    endtask

    task automatic test_rear_pop_wrap();
        send_item(cdq_pkg::ACT_PUSH_REAR, 32'h0000_002a);
        send_item(cdq_pkg::ACT_PUSH_FRONT, 32'hffff_fff9);
        send_item(cdq_pkg::ACT_POP_REAR, 32'h0);
        send_item(cdq_pkg::ACT_POP_FRONT, 32'h0);
    endtask

    task automatic test_back_pressure();
        hold_left = 150;
        for (int i = 0; i < 40; i++)
            send_item(pick_action(2), pick_value());
    endtask

    task automatic test_full_rate();
        idle_in = 0;
        idle_out = 0;
        run_random(300);
        idle_in = 31;
        idle_out = 31;
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        action = cdq_pkg::ACT_PUSH_FRONT;
        value = '0;
        out_ready = 1'b0;
        errors = 0;
        idle_in = 31;
        idle_out = 31;
        hold_left = 0;
        quiet_cycles = 0;
        front_idx = 0;
        rear_idx = 0;
        ring_empty = 1'b1;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_pops();
        test_fill_wrap_drain();
        test_rear_pop_wrap();
        run_random(700);
        test_back_pressure();
        test_full_rate();
        run_random(860);

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DEPTH + 4) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
